/* design/hlme_pkg.sv */
// Package: shared types, constants and neighbor offset table for the hex lattice energy block
package hlme_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic CFG_GRID_SIDE     = 1'b0;
  localparam logic CFG_NICHE_PENALTY = 1'b1;

  localparam logic [8:0] GRID_SIDE_RST     = 9'd100;
  localparam logic [3:0] NICHE_PENALTY_RST = 4'd10;

  localparam logic [1:0] TYPE_STEM = 2'd1;

  localparam int SITE_W = 3;

  // evaluation sequence steps
  localparam logic [4:0] STEP_CENTER1 = 5'd0;
  localparam logic [4:0] STEP_CENTER2 = 5'd1;
  localparam logic [4:0] STEP_NBR1    = 5'd2;
  localparam logic [4:0] STEP_NBR2    = 5'd8;
  localparam logic [4:0] STEP_NICHE1  = 5'd14;
  localparam logic [4:0] STEP_NICHE2  = 5'd15;
  localparam logic [4:0] STEP_LAST    = 5'd16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_EVAL,
    ST_DECIDE,
    ST_WB1,
    ST_WB2,
    ST_REPORT
  } state_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_CLEAR,
    ACC_CENTER1,
    ACC_CENTER2,
    ACC_NBR1,
    ACC_NBR2,
    ACC_NICHE1,
    ACC_NICHE2
  } acc_op_t;

  typedef struct packed {
    acc_op_t op;
    logic    nbr_ok;
  } acc_ctrl_t;

  typedef struct packed {
    logic [1:0]        t1;
    logic              n1;
    logic [1:0]        t2;
    logic              n2;
    logic signed [6:0] acc;
  } acc_stat_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
  } offs_t;

  function automatic offs_t hex_offset(input logic odd, input logic [2:0] k);
    offs_t o;
    o = '0;
    if (odd) begin
      unique case (k)
        3'd0: o = '{dx: -2'sd1, dy: 2'sd0};
        3'd1: o = '{dx: 2'sd1, dy: 2'sd0};
        3'd2: o = '{dx: -2'sd1, dy: -2'sd1};
        3'd3: o = '{dx: 2'sd0, dy: -2'sd1};
        3'd4: o = '{dx: -2'sd1, dy: 2'sd1};
        3'd5: o = '{dx: 2'sd0, dy: 2'sd1};
        default: o = '0;
      endcase
    end else begin
      unique case (k)
        3'd0: o = '{dx: -2'sd1, dy: 2'sd0};
        3'd1: o = '{dx: 2'sd1, dy: 2'sd0};
        3'd2: o = '{dx: 2'sd0, dy: -2'sd1};
        3'd3: o = '{dx: 2'sd1, dy: -2'sd1};
        3'd4: o = '{dx: 2'sd0, dy: 2'sd1};
        3'd5: o = '{dx: 2'sd1, dy: 2'sd1};
        default: o = '0;
      endcase
    end
    return o;
  endfunction

endpackage

/* design/hlme_ram.sv */
// Single-port lattice memory: site type and niche bit per entry, registered read
module hlme_ram
  import hlme_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     addr,
  input  logic [SITE_W-1:0] wdata,
  output logic [SITE_W-1:0] rdata
);

  logic [SITE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/hlme_accum.sv */
// Shared energy accumulator: captures center sites and sums neighbor and niche terms
module hlme_accum
  import hlme_pkg::*;
(
  input  logic              clk,
  input  acc_ctrl_t         ctrl,
  input  logic [SITE_W-1:0] rdata,
  input  logic [3:0]        penalty,
  output acc_stat_t         stat
);

  logic [1:0]        t1, t2;
  logic              n1, n2;
  logic signed [6:0] acc;
  logic signed [6:0] term;
  logic [1:0]        v;

  // neighbor of type v counts toward energy of cell type t
  function automatic logic counts(input logic [1:0] t, input logic [1:0] nv);
    counts = (t == TYPE_STEM) ? nv[1] : (nv == TYPE_STEM);
  endfunction

  function automatic logic signed [6:0] pen(input logic [1:0] t, input logic n,
                                            input logic [3:0] p);
    pen = ((t == TYPE_STEM) ^ n) ? signed'({3'b000, p}) : 7'sd0;
  endfunction

  assign v = rdata[2:1];

  always_comb begin
    term = 7'sd0;
    unique case (ctrl.op)
      ACC_NBR1: begin
        if (ctrl.nbr_ok) begin
          term = signed'({6'd0, counts(t2, v)}) - signed'({6'd0, counts(t1, v)});
        end
      end
      ACC_NBR2: begin
        if (ctrl.nbr_ok) begin
          term = signed'({6'd0, counts(t1, v)}) - signed'({6'd0, counts(t2, v)});
        end
      end
      ACC_NICHE1: term = pen(t2, n1, penalty) - pen(t1, n1, penalty);
      ACC_NICHE2: term = pen(t1, n2, penalty) - pen(t2, n2, penalty);
      default:    term = 7'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      ACC_CLEAR:   acc <= 7'sd0;
      ACC_CENTER1: begin
        t1 <= rdata[2:1];
        n1 <= rdata[0];
      end
      ACC_CENTER2: begin
        t2 <= rdata[2:1];
        n2 <= rdata[0];
      end
      ACC_NBR1, ACC_NBR2, ACC_NICHE1, ACC_NICHE2: acc <= acc + term;
      default: ;
    endcase
  end

  assign stat = '{t1: t1, n1: n1, t2: t2, n2: n2, acc: acc};

endmodule

/* design/hex_lattice_migration_energy_unit.sv */
// Top level: hex lattice migration energy unit with sequencer and lattice port control
//
// Input channel (in_valid/in_ready) takes one command per beat: a site write or a
// pair evaluation. Output channel (out_valid/out_ready) returns one beat per
// evaluation and per out-of-grid command; a good write returns nothing.
// Configuration: cfg_we with cfg_index 0 sets grid_side, 1 sets niche_penalty.
// After reset the lattice is swept to empty, one entry per cycle, over all
// MAX_SIDE*MAX_SIDE entries; in_ready stays low during the sweep.
// Sequence per command, from input beat to result in the output register:
//   write command: no result; ST_WRITE stores the site, then the next is taken.
//   out-of-grid command: goes to ST_REPORT; the next command is taken after it.
//   evaluation: reads and sums in ST_EVAL, judges in ST_DECIDE, writes back in ST_WB1
//   and ST_WB2 if exchanged, then reports; the next command is taken after the report.
//   Its length is set by 14 reads (two centers, twelve neighbors) and 2 write-backs
//   on the single lattice port, plus two niche passes through the shared accumulator.
// The output register holds a result until taken; the block may accept the next
// command meanwhile, and stalls only when a new result finds the register full.
module hex_lattice_migration_energy_unit
  import hlme_pkg::*;
#(
  parameter int MAX_SIDE = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [7:0]        first_x,
  input  logic [7:0]        first_y,
  input  logic [7:0]        second_x,
  input  logic [7:0]        second_y,
  input  logic [1:0]        site_type,
  input  logic              site_niche,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [6:0] energy_change,
  output logic              swapped,
  output logic              coord_error
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [9:0]    SIDE_MAX_W = 10'(MAX_SIDE);
  localparam logic [AW-1:0] CLR_LAST   = AW'(DEPTH - 1);

  state_t state, state_next;

  logic [8:0]  grid_side;
  logic [3:0]  niche_penalty;
  logic [9:0]  side_eff;

  logic [AW-1:0] clr_addr;
  logic [4:0]    step;
  logic [3:0]    tag;
  logic          tag_valid;
  logic          nbr_ok;

  logic          cmd;
  logic [7:0]    x1, y1, x2, y2;
  logic [1:0]    wr_type;
  logic          wr_niche;
  logic          res_err;
  logic          res_swap;

  logic          accept;
  logic          in_err;
  logic          out_free;

  // ram and address unit
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [SITE_W-1:0] ram_wdata;
  logic [SITE_W-1:0] ram_rdata;
  logic              sel_p2;
  logic              use_off;
  logic [2:0]        off_k;
  logic [7:0]        cx, cy;
  offs_t             off;
  logic [9:0]        nx, ny;
  logic              site_ok;
  logic [AW-1:0]     site_addr;

  acc_ctrl_t acc_ctl;
  acc_stat_t acc_st;

  assign side_eff = ({1'b0, grid_side} > SIDE_MAX_W) ? SIDE_MAX_W : {1'b0, grid_side};
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    in_err = ({2'b00, first_x} >= side_eff) || ({2'b00, first_y} >= side_eff);
    if (command == CMD_EVAL) begin
      in_err = in_err || ({2'b00, second_x} >= side_eff) || ({2'b00, second_y} >= side_eff);
    end
  end

  // shared address unit
  assign cx  = sel_p2 ? x2 : x1;
  assign cy  = sel_p2 ? y2 : y1;
  assign off = use_off ? hex_offset(cy[0], off_k) : '0;
  assign nx  = {2'b00, cx} + {{8{off.dx[1]}}, off.dx};
  assign ny  = {2'b00, cy} + {{8{off.dy[1]}}, off.dy};
  assign site_ok   = !nx[9] && !ny[9] && (nx < side_eff) && (ny < side_eff);
  assign site_addr = AW'(ny[8:0]) * AW'(MAX_SIDE) + AW'(nx[8:0]);

  assign ram_addr = (state == ST_CLEAR) ? clr_addr : site_addr;

  hlme_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  hlme_accum u_accum (
    .clk     (clk),
    .ctrl    (acc_ctl),
    .rdata   (ram_rdata),
    .penalty (niche_penalty),
    .stat    (acc_st)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_err) begin
            state_next = ST_REPORT;
          end else if (command == CMD_WRITE) begin
            state_next = ST_WRITE;
          end else begin
            state_next = ST_EVAL;
          end
        end
      end
      ST_WRITE:  state_next = ST_IDLE;
      ST_EVAL:   if (step == STEP_LAST) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (acc_st.acc[6] || (acc_st.acc == 7'sd0)) begin
          state_next = ST_WB1;
        end else begin
          state_next = ST_REPORT;
        end
      end
      ST_WB1:    state_next = ST_WB2;
      ST_WB2:    state_next = ST_REPORT;
      ST_REPORT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    sel_p2    = 1'b0;
    use_off   = 1'b0;
    off_k     = 3'd0;
    acc_ctl   = '{op: ACC_NONE, nbr_ok: nbr_ok};
    unique case (state)
      ST_CLEAR: ram_we = 1'b1;
      ST_IDLE: begin
        if (accept && (command == CMD_EVAL) && !in_err) acc_ctl.op = ACC_CLEAR;
      end
      ST_WRITE: begin
        ram_we    = (cmd == CMD_WRITE);
        ram_wdata = {wr_type, wr_niche};
      end
      ST_EVAL: begin
        if (step == STEP_CENTER2) begin
          sel_p2 = 1'b1;
        end else if ((step >= STEP_NBR1) && (step < STEP_NBR2)) begin
          use_off = 1'b1;
          off_k   = 3'(step - STEP_NBR1);
        end else if ((step >= STEP_NBR2) && (step < STEP_NICHE1)) begin
          sel_p2  = 1'b1;
          use_off = 1'b1;
          off_k   = 3'(step - STEP_NBR2);
        end
      end
      ST_WB1: begin
        ram_we    = 1'b1;
        ram_wdata = {acc_st.t2, acc_st.n1};
      end
      ST_WB2: begin
        ram_we    = 1'b1;
        sel_p2    = 1'b1;
        ram_wdata = {acc_st.t1, acc_st.n2};
      end
      default: ;
    endcase
    if (tag_valid) begin
      if ({1'b0, tag} == STEP_CENTER1) begin
        acc_ctl.op = ACC_CENTER1;
      end else if ({1'b0, tag} == STEP_CENTER2) begin
        acc_ctl.op = ACC_CENTER2;
      end else if ({1'b0, tag} < STEP_NBR2) begin
        acc_ctl.op = ACC_NBR1;
      end else if ({1'b0, tag} < STEP_NICHE1) begin
        acc_ctl.op = ACC_NBR2;
      end else if ({1'b0, tag} == STEP_NICHE1) begin
        acc_ctl.op = ACC_NICHE1;
      end else begin
        acc_ctl.op = ACC_NICHE2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      grid_side     <= GRID_SIDE_RST;
      niche_penalty <= NICHE_PENALTY_RST;
      clr_addr      <= '0;
      step          <= '0;
      tag_valid     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_SIDE:     grid_side     <= cfg_data;
          CFG_NICHE_PENALTY: niche_penalty <= cfg_data[3:0];
        endcase
      end
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      step      <= (state == ST_EVAL) ? step + 5'd1 : 5'd0;
      tag_valid <= (state == ST_EVAL) && !step[4];
      if ((state == ST_REPORT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag    <= step[3:0];
    nbr_ok <= site_ok;
    if (accept) begin
      cmd      <= command;
      x1       <= first_x;
      y1       <= first_y;
      x2       <= second_x;
      y2       <= second_y;
      wr_type  <= site_type;
      wr_niche <= site_niche;
      res_err  <= in_err;
      res_swap <= 1'b0;
    end
    if (state == ST_DECIDE) res_swap <= acc_st.acc[6] || (acc_st.acc == 7'sd0);
    if ((state == ST_REPORT) && out_free) begin
      energy_change <= res_err ? 7'sd0 : acc_st.acc;
      swapped       <= res_swap;
      coord_error   <= res_err;
    end
  end

endmodule
